// ----- sv/skt_pkg.sv -----
package skt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int HND_W    = 16;
    localparam int STAT_W   = 3;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_FIND   = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_REPLACED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

    // Broadcast from the table control to every cell.
    typedef struct packed {
        logic             insert;
        logic             replace;
        logic [KEY_W-1:0] key;
        logic [HND_W-1:0] handle;
    } t_cell_ctl;

endpackage

// ----- sv/skt_cell.sv -----
module skt_cell (
    input  logic                      i_clk,
    input  skt_pkg::t_cell_ctl        i_ctl,
    input  logic                      i_occupied,
    input  logic                      i_left_lt,
    input  logic [skt_pkg::KEY_W-1:0] i_left_key,
    input  logic [skt_pkg::HND_W-1:0] i_left_handle,
    output logic [skt_pkg::KEY_W-1:0] o_key,
    output logic [skt_pkg::HND_W-1:0] o_handle,
    output logic                      o_lt,
    output logic                      o_hit
);

    logic [skt_pkg::KEY_W-1:0] r_key;
    logic [skt_pkg::KEY_W-1:0] n_key;
    logic [skt_pkg::HND_W-1:0] r_handle;
    logic [skt_pkg::HND_W-1:0] n_handle;

    assign o_lt     = i_occupied && (r_key < i_ctl.key);
    assign o_hit    = i_occupied && (r_key == i_ctl.key);
    assign o_key    = r_key;
    assign o_handle = r_handle;

    always_comb begin
        n_key    = r_key;
        n_handle = r_handle;
        if (i_ctl.insert && !o_lt) begin
            // first cell at or above the new key takes it; the rest shift right
            if (i_left_lt) begin
                n_key    = i_ctl.key;
                n_handle = i_ctl.handle;
            end else begin
                n_key    = i_left_key;
                n_handle = i_left_handle;
            end
        end else if (i_ctl.replace && o_hit) begin
            n_handle = i_ctl.handle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_handle <= n_handle;
    end

endmodule

// ----- sv/sorted_key_table.sv -----
// Sorted key table: a row of cells kept in ascending key order.
// The result is registered and valid in the cycle after the request is accepted.
// Throughput: 1 request per cycle while not stalled; every cell compares against
// the key in parallel; on an insert, cells at or above the new key shift right.
// Reset (synchronous, active low) empties the table and drops any pending result.
module sorted_key_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_req_type,
    input  logic [skt_pkg::KEY_W-1:0]  i_key_offset,
    input  logic [skt_pkg::HND_W-1:0]  i_entry_handle,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [skt_pkg::STAT_W-1:0] o_status,
    output logic [skt_pkg::HND_W-1:0]  o_result_handle
);

    logic [skt_pkg::KEY_W-1:0]    w_key    [skt_pkg::CAPACITY];
    logic [skt_pkg::HND_W-1:0]    w_handle [skt_pkg::CAPACITY];
    logic [skt_pkg::CAPACITY-1:0] w_lt;
    logic [skt_pkg::CAPACITY-1:0] w_hit;
    logic [skt_pkg::CAPACITY-1:0] w_occupied;

    logic [skt_pkg::CNT_W-1:0]  r_count;
    logic [skt_pkg::CNT_W-1:0]  n_count;
    logic                       r_out_valid;
    logic [skt_pkg::STAT_W-1:0] r_status;
    logic [skt_pkg::STAT_W-1:0] n_status;
    logic [skt_pkg::HND_W-1:0]  r_res_handle;
    logic [skt_pkg::HND_W-1:0]  n_res_handle;

    logic                       accept;
    logic                       any_hit;
    logic                       full;
    logic [skt_pkg::HND_W-1:0]  hit_handle;
    skt_pkg::t_cell_ctl         ctl;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign any_hit = |w_hit;
    assign full    = (r_count == skt_pkg::CNT_W'(skt_pkg::CAPACITY));

    assign ctl.key     = i_key_offset;
    assign ctl.handle  = i_entry_handle;
    assign ctl.insert  = accept && (i_req_type == skt_pkg::REQ_INSERT) && !any_hit && !full;
    assign ctl.replace = accept && (i_req_type == skt_pkg::REQ_INSERT) && any_hit;

    genvar g;
    generate
        for (g = 0; g < skt_pkg::CAPACITY; g++) begin : g_cell
            assign w_occupied[g] = (skt_pkg::CNT_W'(g) < r_count);
            if (g == 0) begin : g_head
                skt_cell u_cell (
                    .i_clk         (i_clk),
                    .i_ctl         (ctl),
                    .i_occupied    (w_occupied[g]),
                    .i_left_lt     (1'b1),
                    .i_left_key    (i_key_offset),
                    .i_left_handle (i_entry_handle),
                    .o_key         (w_key[g]),
                    .o_handle      (w_handle[g]),
                    .o_lt          (w_lt[g]),
                    .o_hit         (w_hit[g])
                );
            end else begin : g_body
                skt_cell u_cell (
                    .i_clk         (i_clk),
                    .i_ctl         (ctl),
                    .i_occupied    (w_occupied[g]),
                    .i_left_lt     (w_lt[g-1]),
                    .i_left_key    (w_key[g-1]),
                    .i_left_handle (w_handle[g-1]),
                    .o_key         (w_key[g]),
                    .o_handle      (w_handle[g]),
                    .o_lt          (w_lt[g]),
                    .o_hit         (w_hit[g])
                );
            end
        end
    endgenerate

    // At most one cell matches, so an OR of the gated handles selects it.
    always_comb begin
        hit_handle = '0;
        for (int i = 0; i < skt_pkg::CAPACITY; i++) begin
            hit_handle = hit_handle | (w_hit[i] ? w_handle[i] : '0);
        end
    end

    always_comb begin
        n_res_handle = '0;
        if (i_req_type == skt_pkg::REQ_FIND) begin
            if (any_hit) begin
                n_status     = skt_pkg::ST_FOUND;
                n_res_handle = hit_handle;
            end else begin
                n_status = skt_pkg::ST_NOT_FOUND;
            end
        end else if (any_hit) begin
            n_status     = skt_pkg::ST_REPLACED;
            n_res_handle = hit_handle;
        end else if (full) begin
            n_status = skt_pkg::ST_FULL;
        end else begin
            n_status = skt_pkg::ST_INSERTED;
        end
    end

    assign n_count = ctl.insert ? r_count + skt_pkg::CNT_W'(1) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result while the downstream side stalls.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status     <= n_status;
            r_res_handle <= n_res_handle;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_result_handle = r_res_handle;

endmodule

// ----- tb/sv/testbench.sv -----
typedef struct packed {
    logic [skt_pkg::STAT_W-1:0] status;
    logic [skt_pkg::HND_W-1:0]  handle;
} t_table_reply;

// Mirrors the sorted table and holds the replies still owed by the block.
class key_table_shadow;
    logic [skt_pkg::KEY_W-1:0] keys [skt_pkg::CAPACITY];
    logic [skt_pkg::HND_W-1:0] handles [skt_pkg::CAPACITY];
    int unsigned               count;
    t_table_reply              pending_replies [$];
    int unsigned               mismatches;

    function new();
        count      = 0;
        mismatches = 0;
    endfunction

    function void note_request(logic req_type, logic [skt_pkg::KEY_W-1:0] key,
                               logic [skt_pkg::HND_W-1:0] handle);
        int unsigned  pos;
        int unsigned  i;
        bit           hit;
        t_table_reply reply;
        pos = 0;
        while (pos < count && keys[pos] < key) pos++;
        hit = (pos < count) && (keys[pos] == key);
        reply.handle = '0;
        if (req_type == skt_pkg::REQ_FIND) begin
            if (hit) begin
                reply.status = skt_pkg::ST_FOUND;
                reply.handle = handles[pos];
            end else begin
                reply.status = skt_pkg::ST_NOT_FOUND;
            end
        end else if (hit) begin
            reply.status  = skt_pkg::ST_REPLACED;
            reply.handle  = handles[pos];
            handles[pos]  = handle;
        end else if (count >= skt_pkg::CAPACITY) begin
            reply.status = skt_pkg::ST_FULL;
        end else begin
            // shift the tail right by one to open the slot
            for (i = count; i > pos; i--) begin
                keys[i]    = keys[i-1];
                handles[i] = handles[i-1];
            end
            keys[pos]    = key;
            handles[pos] = handle;
            count++;
            reply.status = skt_pkg::ST_INSERTED;
        end
        pending_replies.push_back(reply);
    endfunction

    function void check_reply(logic [skt_pkg::STAT_W-1:0] status,
                              logic [skt_pkg::HND_W-1:0] handle);
        t_table_reply want;
        if (pending_replies.size() == 0) begin
            $error("unexpected result: status %0d, result_handle 0x%04h", status, handle);
            mismatches++;
        end else begin
            want = pending_replies.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                mismatches++;
            end
            if (handle !== want.handle) begin
                $error("result_handle: expected 0x%04h, got 0x%04h", want.handle, handle);
                mismatches++;
            end
        end
    endfunction
endclass

module testbench;

    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_WAIT     = 16;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_valid        = 1'b0;
    logic                       o_stall;
    logic                       i_req_type     = skt_pkg::REQ_INSERT;
    logic [skt_pkg::KEY_W-1:0]  i_key_offset   = '0;
    logic [skt_pkg::HND_W-1:0]  i_entry_handle = '0;
    logic                       o_valid;
    logic                       i_stall        = 1'b0;
    logic [skt_pkg::STAT_W-1:0] o_status;
    logic [skt_pkg::HND_W-1:0]  o_result_handle;

    key_table_shadow table_shadow = new();
    int unsigned     cycle_count  = 0;
    int unsigned     reply_count  = 0;

    sorted_key_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_key_offset    (i_key_offset),
        .i_entry_handle  (i_entry_handle),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_result_handle (o_result_handle)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hold the request until the block takes it, then record the expected reply.
    task automatic send_request(logic req_type, logic [skt_pkg::KEY_W-1:0] key,
                                logic [skt_pkg::HND_W-1:0] handle, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= req_type;
        i_key_offset   <= key;
        i_entry_handle <= handle;
        do @(posedge i_clk); while (o_stall);
        table_shadow.note_request(req_type, key, handle);
    endtask

    // Favor keys already in the table so replace and find hit often.
    function automatic logic [skt_pkg::KEY_W-1:0] pick_key();
        logic [skt_pkg::KEY_W-1:0] key;
        int unsigned               sel;
        sel = $urandom_range(0, 9);
        key = $urandom();
        if (table_shadow.count > 0 && sel <= 5) begin
            key = table_shadow.keys[$urandom_range(0, table_shadow.count - 1)];
            if (sel == 5) key = $urandom_range(0, 1) ? key + 1'b1 : key - 1'b1;
        end else if (sel == 6) begin
            key = $urandom_range(0, 1) ? '1 : '0;
        end
        return key;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            table_shadow.check_reply(o_status, o_result_handle);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk) cycle_count++;
        $display("FAIL sorted_key_table");
        $finish;
    end

    // Receiver: random stall before each result, none in every third run of 80.
    initial begin
        int unsigned hold;
        repeat (8) @(posedge i_clk);
        forever begin
            hold = ((reply_count / 80) % 3 == 2) ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
            reply_count++;
        end
    end

    initial begin
        int unsigned      n;
        int unsigned      gap;
        logic             req_type;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty-table find, inserts at both ends and the middle, finds, replaces
        send_request(skt_pkg::REQ_FIND,   32'h0000_0000, 16'hFFFF,
                     $urandom_range(0, MAX_WAIT));
        send_request(skt_pkg::REQ_INSERT, 32'h8000_0000, 16'h0000,
                     $urandom_range(0, MAX_WAIT));
        send_request(skt_pkg::REQ_INSERT, 32'h0000_0000, 16'hFFFF, 0);
        send_request(skt_pkg::REQ_INSERT, 32'hFFFF_FFFF, 16'h0001, 0);
        send_request(skt_pkg::REQ_INSERT, 32'h7FFF_FFFF, 16'h5555,
                     $urandom_range(0, MAX_WAIT));
        send_request(skt_pkg::REQ_INSERT, 32'h8000_0001, 16'hAAAA, 0);
        send_request(skt_pkg::REQ_FIND,   32'h8000_0000, 16'h1234, 0);
        send_request(skt_pkg::REQ_INSERT, 32'h0000_0000, 16'h1234,
                     $urandom_range(0, MAX_WAIT));
        send_request(skt_pkg::REQ_FIND,   32'h0000_0000, 16'h0000, 0);
        send_request(skt_pkg::REQ_FIND,   32'hFFFF_FFFF, 16'hFFFF, 0);
        send_request(skt_pkg::REQ_FIND,   32'h0000_0001, 16'h0000,
                     $urandom_range(0, MAX_WAIT));
        send_request(skt_pkg::REQ_FIND,   32'hFFFF_FFFE, 16'h0000, 0);
        send_request(skt_pkg::REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 0);
        send_request(skt_pkg::REQ_FIND,   32'hFFFF_FFFF, 16'h0000,
                     $urandom_range(0, MAX_WAIT));
        send_request(skt_pkg::REQ_INSERT, 32'h8000_0000, 16'h8000, 0);

        // random mix; the table fills early, so later inserts of new keys hit full
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            gap      = ((n / 100) % 4 == 1) ? 0 : $urandom_range(0, MAX_WAIT);
            req_type = ($urandom_range(0, 9) < 6) ? skt_pkg::REQ_INSERT : skt_pkg::REQ_FIND;
            send_request(req_type, pick_key(), skt_pkg::HND_W'($urandom()), gap);
        end
        i_valid <= 1'b0;

        while (table_shadow.pending_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (table_shadow.mismatches == 0 && table_shadow.pending_replies.size() == 0) begin
            $display("PASS sorted_key_table");
        end else begin
            $display("FAIL sorted_key_table");
        end
        $finish;
    end

endmodule

// ----- sorted_key_table.f -----
sv/skt_pkg.sv
sv/skt_cell.sv
sv/sorted_key_table.sv
tb/sv/testbench.sv
